[sv/rti_pkg.sv]
// Shared constants and width helpers for the ray/triangle intersection block.
package rti_pkg;

  // Quotient bits produced by each divider, one more than the width of t.
  localparam int QuotW = 33;
  // Fraction bits of t, u and v.
  localparam int QFrac = 16;
  localparam int TW    = 32;
  localparam int UvW   = 17;
  localparam int FifoDepth = 4;

  localparam logic signed [TW-1:0] TMax = 32'sh7fff_ffff;
  localparam logic signed [TW-1:0] TMin = 32'sh8000_0000;
  localparam logic [QuotW-1:0]     TNegLim = 33'h0_8000_0000;

  // Edge vector width.
  function automatic int edge_w(input int c);
    return c + 1;
  endfunction

  // Cross product component width.
  function automatic int cross_w(input int c);
    return 2 * (c + 1) + 1;
  endfunction

  // Width of one dot product term.
  function automatic int dterm_w(input int c);
    return (c + 1) + cross_w(c);
  endfunction

  // Width of a full dot product.
  function automatic int dot_w(input int c);
    return dterm_w(c) + 2;
  endfunction

endpackage

[sv/rti_req_if.sv]
// Request channel: one ray and one triangle per word.
interface rti_req_if #(
  parameter int COORD_WIDTH = 16,
  parameter int TAG_WIDTH   = 32
) ();
  logic                       valid;
  logic                       ready;
  logic [3*COORD_WIDTH-1:0]   ray_origin;
  logic [3*COORD_WIDTH-1:0]   ray_direction;
  logic [3*COORD_WIDTH-1:0]   vertex_zero;
  logic [3*COORD_WIDTH-1:0]   vertex_one;
  logic [3*COORD_WIDTH-1:0]   vertex_two;
  logic [TAG_WIDTH-1:0]       triangle_tag;

  modport source (output valid, ray_origin, ray_direction, vertex_zero, vertex_one,
                  vertex_two, triangle_tag, input ready);
  modport sink   (input valid, ray_origin, ray_direction, vertex_zero, vertex_one,
                  vertex_two, triangle_tag, output ready);
endinterface

[sv/rti_res_if.sv]
// Result channel: hit flag, distance, barycentrics, hit point and tag per word.
interface rti_res_if #(
  parameter int COORD_WIDTH = 16,
  parameter int TAG_WIDTH   = 32
) ();
  logic                       valid;
  logic                       ready;
  logic                       hit_flag;
  logic signed [31:0]         ray_distance;
  logic [16:0]                bary_u;
  logic [16:0]                bary_v;
  logic [3*COORD_WIDTH-1:0]   hit_point;
  logic [TAG_WIDTH-1:0]       tag_out;

  modport source (output valid, hit_flag, ray_distance, bary_u, bary_v, hit_point,
                  tag_out, input ready);
  modport sink   (input valid, hit_flag, ray_distance, bary_u, bary_v, hit_point,
                  tag_out, output ready);
endinterface

[sv/rti_fifo.sv]
// Small register queue between the geometry front end and the divide back end.
module rti_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);
  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [AW:0]      count_q;

  assign full_o  = (count_q == (AW+1)'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && pop_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("word pushed into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("word popped from empty queue");
  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count lost a push");
`endif
endmodule

[sv/rti_front.sv]
// Geometry front end: edges, cross products, dot products and hit classification.
module rti_front #(
  parameter int COORD_WIDTH = 16,
  parameter int TAG_WIDTH   = 32
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             in_valid_i,
  output logic                                             in_ready_o,
  input  logic [3*COORD_WIDTH-1:0]                         ray_origin_i,
  input  logic [3*COORD_WIDTH-1:0]                         ray_direction_i,
  input  logic [3*COORD_WIDTH-1:0]                         vertex_zero_i,
  input  logic [3*COORD_WIDTH-1:0]                         vertex_one_i,
  input  logic [3*COORD_WIDTH-1:0]                         vertex_two_i,
  input  logic [TAG_WIDTH-1:0]                             triangle_tag_i,
  output logic                                             push_o,
  input  logic                                             full_i,
  output logic                                             hit_o,
  output logic signed [rti_pkg::dot_w(COORD_WIDTH)-1:0]    det_o,
  output logic signed [rti_pkg::dot_w(COORD_WIDTH)-1:0]    u_o,
  output logic signed [rti_pkg::dot_w(COORD_WIDTH)-1:0]    v_o,
  output logic signed [rti_pkg::dot_w(COORD_WIDTH)-1:0]    tr_o,
  output logic [3*COORD_WIDTH-1:0]                         org_o,
  output logic [3*COORD_WIDTH-1:0]                         dir_o,
  output logic [TAG_WIDTH-1:0]                             tag_o
);
  import rti_pkg::*;

  localparam int C   = COORD_WIDTH;
  localparam int CW  = edge_w(C);
  localparam int PW  = 2 * CW;
  localparam int XW  = cross_w(C);
  localparam int DPW = dterm_w(C);
  localparam int DW  = dot_w(C);
  localparam int VW  = 3 * C;

  logic en;
  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  // stage 1: edges
  logic signed [CW-1:0] e1_1_q [3], e2_1_q [3], tv_1_q [3];
  logic [VW-1:0]        org_1_q, dir_1_q;
  logic [TAG_WIDTH-1:0] tag_1_q;
  // stage 2: cross product terms
  logic signed [PW-1:0] pa_q [3], pb_q [3], qa_q [3], qb_q [3];
  logic signed [CW-1:0] e1_2_q [3], e2_2_q [3], tv_2_q [3];
  logic [VW-1:0]        org_2_q, dir_2_q;
  logic [TAG_WIDTH-1:0] tag_2_q;
  // stage 3: cross products
  logic signed [XW-1:0] p_q [3], q_q [3];
  logic signed [CW-1:0] e1_3_q [3], e2_3_q [3], tv_3_q [3];
  logic [VW-1:0]        org_3_q, dir_3_q;
  logic [TAG_WIDTH-1:0] tag_3_q;
  // stage 4: dot product terms
  logic signed [DPW-1:0] dm_q [3], um_q [3], vm_q [3], tm_q [3];
  logic [VW-1:0]         org_4_q, dir_4_q;
  logic [TAG_WIDTH-1:0]  tag_4_q;
  // stage 5: dot products
  logic signed [DW-1:0]  det_q, u_q, v_q, tr_q;
  logic [VW-1:0]         org_5_q, dir_5_q;
  logic [TAG_WIDTH-1:0]  tag_5_q;

  logic signed [C-1:0]  d_3 [3];
  logic signed [DW:0]   det_u;
  logic signed [DW+1:0] det_uv;

  // hold the whole pipe while the last word waits for queue space
  assign en         = !v5_q || !full_i;
  assign in_ready_o = en;
  assign push_o     = v5_q && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d_3[k] = $signed(dir_3_q[k*C +: C]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        e1_1_q[k] <= CW'($signed(vertex_one_i[k*C +: C]))
                   - CW'($signed(vertex_zero_i[k*C +: C]));
        e2_1_q[k] <= CW'($signed(vertex_two_i[k*C +: C]))
                   - CW'($signed(vertex_zero_i[k*C +: C]));
        tv_1_q[k] <= CW'($signed(ray_origin_i[k*C +: C]))
                   - CW'($signed(vertex_zero_i[k*C +: C]));
      end
      org_1_q <= ray_origin_i;
      dir_1_q <= ray_direction_i;
      tag_1_q <= triangle_tag_i;

      // p = dir x e2, q = tv x e1
      pa_q[0] <= PW'($signed(dir_1_q[1*C +: C])) * PW'(e2_1_q[2]);
      pb_q[0] <= PW'($signed(dir_1_q[2*C +: C])) * PW'(e2_1_q[1]);
      pa_q[1] <= PW'($signed(dir_1_q[2*C +: C])) * PW'(e2_1_q[0]);
      pb_q[1] <= PW'($signed(dir_1_q[0*C +: C])) * PW'(e2_1_q[2]);
      pa_q[2] <= PW'($signed(dir_1_q[0*C +: C])) * PW'(e2_1_q[1]);
      pb_q[2] <= PW'($signed(dir_1_q[1*C +: C])) * PW'(e2_1_q[0]);
      qa_q[0] <= PW'(tv_1_q[1]) * PW'(e1_1_q[2]);
      qb_q[0] <= PW'(tv_1_q[2]) * PW'(e1_1_q[1]);
      qa_q[1] <= PW'(tv_1_q[2]) * PW'(e1_1_q[0]);
      qb_q[1] <= PW'(tv_1_q[0]) * PW'(e1_1_q[2]);
      qa_q[2] <= PW'(tv_1_q[0]) * PW'(e1_1_q[1]);
      qb_q[2] <= PW'(tv_1_q[1]) * PW'(e1_1_q[0]);
      e1_2_q  <= e1_1_q;
      e2_2_q  <= e2_1_q;
      tv_2_q  <= tv_1_q;
      org_2_q <= org_1_q;
      dir_2_q <= dir_1_q;
      tag_2_q <= tag_1_q;

      for (int k = 0; k < 3; k++) begin
        p_q[k] <= XW'(pa_q[k]) - XW'(pb_q[k]);
        q_q[k] <= XW'(qa_q[k]) - XW'(qb_q[k]);
      end
      e1_3_q  <= e1_2_q;
      e2_3_q  <= e2_2_q;
      tv_3_q  <= tv_2_q;
      org_3_q <= org_2_q;
      dir_3_q <= dir_2_q;
      tag_3_q <= tag_2_q;

      for (int k = 0; k < 3; k++) begin
        dm_q[k] <= DPW'(e1_3_q[k]) * DPW'(p_q[k]);
        um_q[k] <= DPW'(tv_3_q[k]) * DPW'(p_q[k]);
        vm_q[k] <= DPW'(d_3[k]) * DPW'(q_q[k]);
        tm_q[k] <= DPW'(e2_3_q[k]) * DPW'(q_q[k]);
      end
      org_4_q <= org_3_q;
      dir_4_q <= dir_3_q;
      tag_4_q <= tag_3_q;

      det_q   <= DW'(dm_q[0]) + DW'(dm_q[1]) + DW'(dm_q[2]);
      u_q     <= DW'(um_q[0]) + DW'(um_q[1]) + DW'(um_q[2]);
      v_q     <= DW'(vm_q[0]) + DW'(vm_q[1]) + DW'(vm_q[2]);
      tr_q    <= DW'(tm_q[0]) + DW'(tm_q[1]) + DW'(tm_q[2]);
      org_5_q <= org_4_q;
      dir_5_q <= dir_4_q;
      tag_5_q <= tag_4_q;
    end
  end

  // front face, u in [0, det], v >= 0, u + v <= det
  assign det_u  = (DW+1)'(det_q) - (DW+1)'(u_q);
  assign det_uv = (DW+2)'(det_q) - (DW+2)'(u_q) - (DW+2)'(v_q);
  assign hit_o  = !det_q[DW-1] && (det_q != '0) && !u_q[DW-1] && !det_u[DW]
               && !v_q[DW-1] && !det_uv[DW+1];

  assign det_o = det_q;
  assign u_o   = u_q;
  assign v_o   = v_q;
  assign tr_o  = tr_q;
  assign org_o = org_5_q;
  assign dir_o = dir_5_q;
  assign tag_o = tag_5_q;
endmodule

[sv/rti_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module rti_div #(
  parameter int DEN_W = 54,
  parameter int Q_W   = 33
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [DEN_W-1:0] r_i,   // partial remainder, below d_i
  input  logic [Q_W-1:0]   n_i,   // numerator bits still to bring down
  input  logic [DEN_W-1:0] d_i,
  output logic [Q_W-1:0]   q_o
);
  logic [DEN_W-1:0] r_q [Q_W];
  logic [Q_W-1:0]   n_q [Q_W];
  logic [DEN_W-1:0] d_q [Q_W];
  logic [Q_W-1:0]   q_q [Q_W];

  logic [DEN_W-1:0] r_d [Q_W];
  logic [Q_W-1:0]   n_d [Q_W];
  logic [DEN_W-1:0] d_d [Q_W];
  logic [Q_W-1:0]   q_d [Q_W];

  always_comb begin
    logic [DEN_W:0]   rr;
    logic [DEN_W-1:0] r_prev, d_prev;
    logic [Q_W-1:0]   n_prev, q_prev;
    for (int k = 0; k < Q_W; k++) begin
      if (k == 0) begin
        r_prev = r_i;
        n_prev = n_i;
        d_prev = d_i;
        q_prev = '0;
      end else begin
        r_prev = r_q[k-1];
        n_prev = n_q[k-1];
        d_prev = d_q[k-1];
        q_prev = q_q[k-1];
      end
      rr = {r_prev, n_prev[Q_W-1]};
      if (rr >= {1'b0, d_prev}) begin
        r_d[k] = DEN_W'(rr - {1'b0, d_prev});
        q_d[k] = {q_prev[Q_W-2:0], 1'b1};
      end else begin
        r_d[k] = DEN_W'(rr);
        q_d[k] = {q_prev[Q_W-2:0], 1'b0};
      end
      n_d[k] = {n_prev[Q_W-2:0], 1'b0};
      d_d[k] = d_prev;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q <= r_d;
      n_q <= n_d;
      d_q <= d_d;
      q_q <= q_d;
    end
  end

  assign q_o = q_q[Q_W-1];
endmodule

[sv/rti_back.sv]
// Divide back end: t, u, v quotients, hit point and the output register.
module rti_back #(
  parameter int COORD_WIDTH = 16,
  parameter int TAG_WIDTH   = 32
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             head_valid_i,
  output logic                                             pop_o,
  input  logic                                             hit_i,
  input  logic signed [rti_pkg::dot_w(COORD_WIDTH)-1:0]    det_i,
  input  logic signed [rti_pkg::dot_w(COORD_WIDTH)-1:0]    u_i,
  input  logic signed [rti_pkg::dot_w(COORD_WIDTH)-1:0]    v_i,
  input  logic signed [rti_pkg::dot_w(COORD_WIDTH)-1:0]    tr_i,
  input  logic [3*COORD_WIDTH-1:0]                         org_i,
  input  logic [3*COORD_WIDTH-1:0]                         dir_i,
  input  logic [TAG_WIDTH-1:0]                             tag_i,
  output logic                                             out_valid_o,
  input  logic                                             out_ready_i,
  output logic                                             hit_flag_o,
  output logic signed [rti_pkg::TW-1:0]                    ray_distance_o,
  output logic [rti_pkg::UvW-1:0]                          bary_u_o,
  output logic [rti_pkg::UvW-1:0]                          bary_v_o,
  output logic [3*COORD_WIDTH-1:0]                         hit_point_o,
  output logic [TAG_WIDTH-1:0]                             tag_out_o
);
  import rti_pkg::*;

  localparam int C   = COORD_WIDTH;
  localparam int DW  = dot_w(C);
  localparam int VW  = 3 * C;
  localparam int SH  = QuotW - QFrac;
  localparam int PR  = TW + C;
  localparam logic signed [PR+1:0] SHi = (PR+2)'((64'sd1 <<< (C-1)) - 64'sd1);
  localparam logic signed [PR+1:0] SLo = ~SHi;
  localparam logic signed [PR:0]   Rnd = (PR+1)'(64'sd1 <<< (QFrac-1));

  typedef struct packed {
    logic                 hit;
    logic                 tneg;
    logic                 tsat;
    logic [VW-1:0]        org;
    logic [VW-1:0]        dir;
    logic [TAG_WIDTH-1:0] tag;
  } side_t;

  logic en;

  // entry stage
  logic                 b0_v_q;
  logic                 hit_0_q;
  logic [DW-1:0]        det_0_q, u_0_q, v_0_q;
  logic signed [DW-1:0] tr_0_q;
  logic [VW-1:0]        org_0_q, dir_0_q;
  logic [TAG_WIDTH-1:0] tag_0_q;
  logic                 tneg;
  logic [DW-1:0]        tmag;
  side_t                side_in;

  // divider shadow line
  logic  side_v_q [QuotW];
  side_t side_q [QuotW];
  logic [QuotW-1:0] qt, qu, qv;

  // t stage
  logic                 b1_v_q, hit_1_q;
  logic signed [TW-1:0] t_1_q;
  logic [UvW-1:0]       u_1_q, v_1_q;
  logic [VW-1:0]        org_1_q, dir_1_q;
  logic [TAG_WIDTH-1:0] tag_1_q;
  logic signed [TW-1:0] t_d;
  side_t                side_out;

  // product stage
  logic                 b2_v_q, hit_2_q;
  logic signed [TW-1:0] t_2_q;
  logic [UvW-1:0]       u_2_q, v_2_q;
  logic [VW-1:0]        org_2_q;
  logic [TAG_WIDTH-1:0] tag_2_q;
  logic signed [PR-1:0] prod_q [3];

  // output register
  logic                 out_v_q, hit_o_q;
  logic signed [TW-1:0] t_o_q;
  logic [UvW-1:0]       u_o_q, v_o_q;
  logic [VW-1:0]        pt_o_q;
  logic [TAG_WIDTH-1:0] tag_o_q;
  logic [VW-1:0]        pt_d;

  // advance everything while the output word is free or being taken
  assign en    = !out_v_q || out_ready_i;
  assign pop_o = en && head_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_v_q <= 1'b0;
      for (int k = 0; k < QuotW; k++) side_v_q[k] <= 1'b0;
      b1_v_q  <= 1'b0;
      b2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      b0_v_q      <= head_valid_i;
      side_v_q[0] <= b0_v_q;
      for (int k = 1; k < QuotW; k++) side_v_q[k] <= side_v_q[k-1];
      b1_v_q  <= side_v_q[QuotW-1];
      b2_v_q  <= b1_v_q;
      out_v_q <= b2_v_q;
    end
  end

  assign tneg = tr_0_q[DW-1];
  assign tmag = tneg ? DW'(-tr_0_q) : DW'(tr_0_q);

  always_comb begin
    side_in.hit  = hit_0_q;
    side_in.tneg = tneg;
    // quotient would not fit the divider, clamp t
    side_in.tsat = (tmag >> SH) >= det_0_q;
    side_in.org  = org_0_q;
    side_in.dir  = dir_0_q;
    side_in.tag  = tag_0_q;
  end

  rti_div #(.DEN_W(DW), .Q_W(QuotW)) u_div_t (
    .clk_i (clk_i), .en_i (en), .r_i (tmag >> SH),
    .n_i ({tmag[SH-1:0], QFrac'(0)}), .d_i (det_0_q), .q_o (qt)
  );
  rti_div #(.DEN_W(DW), .Q_W(QuotW)) u_div_u (
    .clk_i (clk_i), .en_i (en), .r_i (u_0_q >> SH),
    .n_i ({u_0_q[SH-1:0], QFrac'(0)}), .d_i (det_0_q), .q_o (qu)
  );
  rti_div #(.DEN_W(DW), .Q_W(QuotW)) u_div_v (
    .clk_i (clk_i), .en_i (en), .r_i (v_0_q >> SH),
    .n_i ({v_0_q[SH-1:0], QFrac'(0)}), .d_i (det_0_q), .q_o (qv)
  );

  assign side_out = side_q[QuotW-1];

  always_comb begin
    if (side_out.tneg) begin
      t_d = (side_out.tsat || qt > TNegLim) ? TMin : -$signed(qt[TW-1:0]);
    end else begin
      t_d = (side_out.tsat || qt[QuotW-1:TW-1] != '0) ? TMax : $signed(qt[TW-1:0]);
    end
  end

  always_comb begin
    logic signed [PR:0]   rnd;
    logic signed [PR+1:0] s;
    pt_d = '0;
    for (int k = 0; k < 3; k++) begin
      rnd = (PR+1)'(prod_q[k]) + Rnd;
      s   = (PR+2)'($signed(org_2_q[k*C +: C])) + (PR+2)'(rnd >>> QFrac);
      if (s < SLo)      s = SLo;
      else if (s > SHi) s = SHi;
      pt_d[k*C +: C] = s[C-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_0_q <= hit_i;
      det_0_q <= det_i;
      u_0_q   <= u_i;
      v_0_q   <= v_i;
      tr_0_q  <= tr_i;
      org_0_q <= org_i;
      dir_0_q <= dir_i;
      tag_0_q <= tag_i;

      side_q[0] <= side_in;
      for (int k = 1; k < QuotW; k++) side_q[k] <= side_q[k-1];

      hit_1_q <= side_out.hit;
      t_1_q   <= t_d;
      u_1_q   <= qu[UvW-1:0];
      v_1_q   <= qv[UvW-1:0];
      org_1_q <= side_out.org;
      dir_1_q <= side_out.dir;
      tag_1_q <= side_out.tag;

      for (int k = 0; k < 3; k++) begin
        prod_q[k] <= PR'(t_1_q) * PR'($signed(dir_1_q[k*C +: C]));
      end
      hit_2_q <= hit_1_q;
      t_2_q   <= t_1_q;
      u_2_q   <= u_1_q;
      v_2_q   <= v_1_q;
      org_2_q <= org_1_q;
      tag_2_q <= tag_1_q;

      // zero every field on a miss
      hit_o_q <= hit_2_q;
      t_o_q   <= hit_2_q ? t_2_q : '0;
      u_o_q   <= hit_2_q ? u_2_q : '0;
      v_o_q   <= hit_2_q ? v_2_q : '0;
      pt_o_q  <= hit_2_q ? pt_d : '0;
      tag_o_q <= hit_2_q ? tag_2_q : '0;
    end
  end

  assign out_valid_o    = out_v_q;
  assign hit_flag_o     = hit_o_q;
  assign ray_distance_o = t_o_q;
  assign bary_u_o       = u_o_q;
  assign bary_v_o       = v_o_q;
  assign hit_point_o    = pt_o_q;
  assign tag_out_o      = tag_o_q;
endmodule

[sv/ray_triangle_intersect.sv]
// Top level of the single-sided ray/triangle intersection block.
//
// req_i carries one word per test: ray origin and direction, three vertices
// (each packed x,y,z signed fixed point, x lowest) and a triangle tag.
// res_o returns one word per test, in order: hit flag, distance t (Q16.16,
// saturated), barycentric u and v (Q1.16), hit point and tag; all fields but
// the flag are zero on a miss or a back face.
// Both channels move a word when valid and ready are high at a clock edge.
// Throughput is one word per cycle while res_o does not stall. The path
// runs through five geometry stages, the queue, an entry stage, 33
// divider stages (one quotient bit each) and three stages for t, the hit
// point products and the output register.
// When res_o stalls, the back end holds; the front end drops req_i.ready
// once the four-entry queue is full and a word waits in its last stage.
// Reset (rst_ni low) empties the pipeline and the queue at once.
module ray_triangle_intersect #(
  parameter int COORD_WIDTH = 16,
  parameter int TAG_WIDTH   = 32
) (
  input logic       clk_i,
  input logic       rst_ni,
  rti_req_if.sink   req_i,
  rti_res_if.source res_o
);
  import rti_pkg::*;

  localparam int DW = dot_w(COORD_WIDTH);
  localparam int VW = 3 * COORD_WIDTH;

  typedef struct packed {
    logic                 hit;
    logic [DW-1:0]        det;
    logic [DW-1:0]        u;
    logic [DW-1:0]        v;
    logic [DW-1:0]        tr;
    logic [VW-1:0]        org;
    logic [VW-1:0]        dir;
    logic [TAG_WIDTH-1:0] tag;
  } entry_t;

  entry_t f_entry, b_entry;
  logic   push, full, pop, empty;

  rti_front #(.COORD_WIDTH(COORD_WIDTH), .TAG_WIDTH(TAG_WIDTH)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (req_i.valid),
    .in_ready_o      (req_i.ready),
    .ray_origin_i    (req_i.ray_origin),
    .ray_direction_i (req_i.ray_direction),
    .vertex_zero_i   (req_i.vertex_zero),
    .vertex_one_i    (req_i.vertex_one),
    .vertex_two_i    (req_i.vertex_two),
    .triangle_tag_i  (req_i.triangle_tag),
    .push_o          (push),
    .full_i          (full),
    .hit_o           (f_entry.hit),
    .det_o           (f_entry.det),
    .u_o             (f_entry.u),
    .v_o             (f_entry.v),
    .tr_o            (f_entry.tr),
    .org_o           (f_entry.org),
    .dir_o           (f_entry.dir),
    .tag_o           (f_entry.tag)
  );

  rti_fifo #(.WIDTH($bits(entry_t)), .DEPTH(FifoDepth)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (f_entry),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (b_entry),
    .empty_o (empty)
  );

  rti_back #(.COORD_WIDTH(COORD_WIDTH), .TAG_WIDTH(TAG_WIDTH)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (!empty),
    .pop_o          (pop),
    .hit_i          (b_entry.hit),
    .det_i          (b_entry.det),
    .u_i            (b_entry.u),
    .v_i            (b_entry.v),
    .tr_i           (b_entry.tr),
    .org_i          (b_entry.org),
    .dir_i          (b_entry.dir),
    .tag_i          (b_entry.tag),
    .out_valid_o    (res_o.valid),
    .out_ready_i    (res_o.ready),
    .hit_flag_o     (res_o.hit_flag),
    .ray_distance_o (res_o.ray_distance),
    .bary_u_o       (res_o.bary_u),
    .bary_v_o       (res_o.bary_v),
    .hit_point_o    (res_o.hit_point),
    .tag_out_o      (res_o.tag_out)
  );
endmodule
